/* sv/srfr_pkg.sv */
// Shared types, codes and a helper function of the servo reply frame reassembler.
package srfr_pkg;

  localparam int STORE_WORDS_DEF = 30;
  localparam int WORDS_PER_PACK  = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] FC_PARAM     = 8'h10;
  localparam logic [7:0] FC_SET_ACK   = 8'h11;
  localparam logic [7:0] FC_MONITOR   = 8'h12;
  localparam logic [7:0] FC_ALARM     = 8'h14;
  localparam logic [7:0] FC_ZERO_ACK  = 8'h15;
  localparam logic [7:0] FC_ZERO_DONE = 8'h16;
  localparam logic [7:0] FC_STATUS    = 8'h23;

  localparam logic [3:0] LEN_MIN  = 4'd4;
  localparam logic [3:0] LEN_MID  = 4'd6;
  localparam logic [3:0] LEN_FULL = 4'd8;

  localparam logic STORE_PARAM = 1'b0;
  localparam logic STORE_MON   = 1'b1;

  typedef enum logic [2:0] {
    OP_FRAME     = 3'd0,
    OP_RD_PARAM  = 3'd1,
    OP_RD_MON    = 3'd2,
    OP_RST_PARAM = 3'd3,
    OP_RST_MON   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    EV_IGNORED    = 4'd0,
    EV_ALARM      = 4'd1,
    EV_PARAM_DONE = 4'd2,
    EV_SET_ACK    = 4'd3,
    EV_MON_DONE   = 4'd4,
    EV_ZERO_ACK   = 4'd5,
    EV_ZERO_DONE  = 4'd6,
    EV_STATUS     = 4'd7,
    EV_PACK_OK    = 4'd8,
    EV_PACK_BAD   = 4'd9,
    EV_READ       = 4'd10
  } event_t;

  typedef enum logic [1:0] {
    CMD_EVENT,
    CMD_PACK,
    CMD_READ,
    CMD_RESTART
  } cmd_kind_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    cmd_kind_t                             kind;
    logic                                  sel;
    event_t                                ev;
    logic [7:0]                            code;
    logic                                  pre_bad;
    logic                                  last;
    logic [7:0]                            idx;
    logic [WORDS_PER_PACK-1:0]             wen;
    logic [WORDS_PER_PACK-1:0][15:0]       words;
    logic [7:0]                            rrow;
    logic [1:0]                            lane;
    logic                                  rd_in_range;
  } cmd_t;

  // Divide a 5-bit word index by three: multiply by 11/32, exact below 32
  function automatic logic [3:0] div3_5b(input logic [4:0] val);
    logic [8:0] prod;
    prod = 9'(val) * 9'd11;
    return prod[8:5];
  endfunction

endpackage

/* sv/srfr_front.sv */
// Front part: source filter, function decode and pack pre-checks.
module srfr_front #(
  parameter int STORE_WORDS = srfr_pkg::STORE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic              in_frame_valid,
  input  logic [7:0]        in_source_id,
  input  logic [7:0]        in_function_code,
  input  logic [3:0]        in_data_length,
  input  logic [7:0]        in_byte_zero,
  input  logic [7:0]        in_byte_one,
  input  logic [15:0]       in_word_first,
  input  logic [15:0]       in_word_second,
  input  logic [15:0]       in_word_third,
  input  logic [4:0]        in_read_index,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output srfr_pkg::cmd_t    cmd
);

  localparam int ROWS = STORE_WORDS / srfr_pkg::WORDS_PER_PACK;

  logic [3:0] dev_type_r;
  logic       bad_range;
  logic       bad_len;
  logic       bad_short;
  logic       is_last;
  logic [3:0] rd_row;
  logic [4:0] rd_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_type_r <= '0;
    end else if (cfg_we) begin
      dev_type_r <= cfg_wdata;
    end
  end

  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

  always_comb begin
    bad_range = (in_byte_one >= in_byte_zero) || (in_byte_zero > 8'(ROWS));
    bad_len   = (in_data_length < srfr_pkg::LEN_MIN) || in_data_length[0] ||
                (in_data_length > srfr_pkg::LEN_FULL);
    is_last   = ({1'b0, in_byte_one} + 9'd1) == {1'b0, in_byte_zero};
    bad_short = (in_data_length != srfr_pkg::LEN_FULL) && !is_last;
    rd_row    = srfr_pkg::div3_5b(in_read_index);
    rd_base   = 5'(rd_row) * 5'd3;

    cmd             = '0;
    cmd.kind        = srfr_pkg::CMD_EVENT;
    cmd.ev          = srfr_pkg::EV_IGNORED;
    cmd.pre_bad     = bad_range || bad_len || bad_short;
    cmd.last        = is_last;
    cmd.idx         = in_byte_one;
    cmd.wen         = {in_data_length == srfr_pkg::LEN_FULL,
                       in_data_length >= srfr_pkg::LEN_MID, 1'b1};
    cmd.words       = {in_word_third, in_word_second, in_word_first};
    cmd.rrow        = 8'(rd_row);
    cmd.lane        = 2'(in_read_index - rd_base);
    cmd.rd_in_range = 8'(rd_row) < 8'(ROWS);

    unique case (in_op)
      srfr_pkg::OP_FRAME: begin
        if (in_frame_valid && (in_source_id[7:4] == dev_type_r)) begin
          unique case (in_function_code)
            srfr_pkg::FC_ALARM: begin
              cmd.ev   = srfr_pkg::EV_ALARM;
              cmd.code = in_byte_zero;
            end
            srfr_pkg::FC_PARAM: begin
              cmd.kind = srfr_pkg::CMD_PACK;
              cmd.sel  = srfr_pkg::STORE_PARAM;
            end
            srfr_pkg::FC_SET_ACK:   cmd.ev = srfr_pkg::EV_SET_ACK;
            srfr_pkg::FC_MONITOR: begin
              cmd.kind = srfr_pkg::CMD_PACK;
              cmd.sel  = srfr_pkg::STORE_MON;
            end
            srfr_pkg::FC_ZERO_ACK:  cmd.ev = srfr_pkg::EV_ZERO_ACK;
            srfr_pkg::FC_ZERO_DONE: cmd.ev = srfr_pkg::EV_ZERO_DONE;
            srfr_pkg::FC_STATUS: begin
              cmd.ev   = srfr_pkg::EV_STATUS;
              cmd.code = in_byte_zero;
            end
            default: ;
          endcase
        end
      end
      srfr_pkg::OP_RD_PARAM: begin
        cmd.kind = srfr_pkg::CMD_READ;
        cmd.sel  = srfr_pkg::STORE_PARAM;
      end
      srfr_pkg::OP_RD_MON: begin
        cmd.kind = srfr_pkg::CMD_READ;
        cmd.sel  = srfr_pkg::STORE_MON;
      end
      srfr_pkg::OP_RST_PARAM: begin
        cmd.kind = srfr_pkg::CMD_RESTART;
        cmd.sel  = srfr_pkg::STORE_PARAM;
      end
      srfr_pkg::OP_RST_MON: begin
        cmd.kind = srfr_pkg::CMD_RESTART;
        cmd.sel  = srfr_pkg::STORE_MON;
      end
      default: ;
    endcase
  end

endmodule

/* sv/srfr_queue.sv */
// Short request queue between the front and back parts.
module srfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  srfr_pkg::cmd_t    push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output srfr_pkg::cmd_t    pop_cmd
);

  localparam int DEPTH = srfr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  srfr_pkg::cmd_t slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* sv/srfr_back.sv */
// Back part: sequence check, word stores, buffer reads and the result register.
module srfr_back #(
  parameter int STORE_WORDS = srfr_pkg::STORE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  srfr_pkg::cmd_t    cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_event_res,
  output logic [7:0]        out_code_value,
  output logic [15:0]       out_read_word
);

  localparam int WPP  = srfr_pkg::WORDS_PER_PACK;
  localparam int ROWS = STORE_WORDS / WPP;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FW   = $clog2(ROWS + 1);

  // One memory per store and word lane, one row per pack
  logic [15:0]     mem_r  [2][WPP][ROWS];
  logic [FW-1:0]   fill_r [2][WPP];
  logic [15:0]     rd_r   [2][WPP];

  logic [RW-1:0]     par_exp_r, par_exp_nxt;
  logic [RW-1:0]     mon_exp_r, mon_exp_nxt;
  logic              out_vld_r;
  srfr_pkg::event_t  ev_r, ev_nxt;
  logic [7:0]        code_r, code_nxt;
  logic              sel_r;
  logic [1:0]        lane_r;
  logic              hit_r, hit_nxt;

  logic              fire;
  logic [RW-1:0]     cur_exp;
  logic              pack_ok;
  logic [RW-1:0]     row_w;
  logic [RW-1:0]     row_r;
  logic [WPP-1:0]    we;
  logic              rd_en;

  assign fire      = cmd_valid && (!out_vld_r || out_ready);
  assign cmd_ready = !out_vld_r || out_ready;
  assign row_w     = cmd.idx[RW-1:0];
  assign row_r     = cmd.rrow[RW-1:0];
  assign cur_exp   = (cmd.sel == srfr_pkg::STORE_MON) ? mon_exp_r : par_exp_r;
  assign pack_ok   = !cmd.pre_bad && (cmd.idx == 8'(cur_exp));
  assign rd_en     = fire && (cmd.kind == srfr_pkg::CMD_READ) && cmd.rd_in_range;

  always_comb begin
    par_exp_nxt = par_exp_r;
    mon_exp_nxt = mon_exp_r;
    ev_nxt      = srfr_pkg::EV_IGNORED;
    code_nxt    = '0;
    hit_nxt     = 1'b0;
    we          = '0;
    unique case (cmd.kind)
      srfr_pkg::CMD_EVENT: begin
        ev_nxt   = cmd.ev;
        code_nxt = cmd.code;
      end
      srfr_pkg::CMD_PACK: begin
        if (!pack_ok) begin
          ev_nxt = srfr_pkg::EV_PACK_BAD;
          if (cmd.sel == srfr_pkg::STORE_MON) mon_exp_nxt = '0;
          else                                par_exp_nxt = '0;
        end else begin
          we = cmd.wen;
          if (cmd.last) begin
            ev_nxt = (cmd.sel == srfr_pkg::STORE_MON) ? srfr_pkg::EV_MON_DONE
                                                      : srfr_pkg::EV_PARAM_DONE;
            if (cmd.sel == srfr_pkg::STORE_MON) mon_exp_nxt = '0;
            else                                par_exp_nxt = '0;
          end else begin
            ev_nxt = srfr_pkg::EV_PACK_OK;
            if (cmd.sel == srfr_pkg::STORE_MON) mon_exp_nxt = cur_exp + 1'b1;
            else                                par_exp_nxt = cur_exp + 1'b1;
          end
        end
      end
      srfr_pkg::CMD_READ: begin
        ev_nxt  = srfr_pkg::EV_READ;
        hit_nxt = cmd.rd_in_range && (FW'(row_r) < fill_r[cmd.sel][cmd.lane]);
      end
      srfr_pkg::CMD_RESTART: begin
        if (cmd.sel == srfr_pkg::STORE_MON) mon_exp_nxt = '0;
        else                                par_exp_nxt = '0;
      end
      default: ;
    endcase
    if (!fire) begin
      we = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_exp_r <= '0;
      mon_exp_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        par_exp_r <= par_exp_nxt;
        mon_exp_r <= mon_exp_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Packs land in strict order, so the written rows of each lane form a prefix:
  // a fill mark per lane tells written words from ones that must read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        for (int l = 0; l < WPP; l++) begin
          fill_r[s][l] <= '0;
        end
      end
    end else begin
      for (int l = 0; l < WPP; l++) begin
        if (we[l] && (FW'(row_w) >= fill_r[cmd.sel][l])) begin
          fill_r[cmd.sel][l] <= FW'(row_w) + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < WPP; l++) begin
      if (we[l]) begin
        mem_r[cmd.sel][l][row_w] <= cmd.words[l];
      end
      if (rd_en) begin
        rd_r[0][l] <= mem_r[0][l][row_r];
        rd_r[1][l] <= mem_r[1][l][row_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ev_r   <= ev_nxt;
      code_r <= code_nxt;
      sel_r  <= cmd.sel;
      lane_r <= cmd.lane;
      hit_r  <= hit_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_res  = ev_r;
  assign out_code_value = code_r;
  assign out_read_word  = hit_r ? rd_r[sel_r][lane_r] : '0;

endmodule

/* sv/servo_reply_frame_reassembler.sv */
// Top level of the servo reply frame reassembler: front, request queue and back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in_      | in_valid / in_ready   | op, frame flag, source, function, length,
//           |                       | two bytes, three words, read index
//  out_     | out_valid / out_ready | event_res, code_value, read_word
//  cfg_     | cfg_we (no wait)      | cfg_wdata: expected device type nibble
//
// One request per cycle sustained while out_ready stays high; the clock edge that accepts a
// request fills a queue slot, then the back part runs the store write or read and
// registers the result that it presents.
// The store read port and result register sit in the back part; the two-entry
// queue keeps in_ready high for two requests while out_ready is low.
// Reset is synchronous; per-lane fill marks make the stores read as zero at once.
module servo_reply_frame_reassembler #(
  parameter int STORE_WORDS = srfr_pkg::STORE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic        in_frame_valid,
  input  logic [7:0]  in_source_id,
  input  logic [7:0]  in_function_code,
  input  logic [3:0]  in_data_length,
  input  logic [7:0]  in_byte_zero,
  input  logic [7:0]  in_byte_one,
  input  logic [15:0] in_word_first,
  input  logic [15:0] in_word_second,
  input  logic [15:0] in_word_third,
  input  logic [4:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [7:0]  out_code_value,
  output logic [15:0] out_read_word
);

  logic           f_valid;
  logic           f_ready;
  srfr_pkg::cmd_t f_cmd;
  logic           b_valid;
  logic           b_ready;
  srfr_pkg::cmd_t b_cmd;

  srfr_front #(
    .STORE_WORDS (STORE_WORDS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_frame_valid   (in_frame_valid),
    .in_source_id     (in_source_id),
    .in_function_code (in_function_code),
    .in_data_length   (in_data_length),
    .in_byte_zero     (in_byte_zero),
    .in_byte_one      (in_byte_one),
    .in_word_first    (in_word_first),
    .in_word_second   (in_word_second),
    .in_word_third    (in_word_third),
    .in_read_index    (in_read_index),
    .cmd_valid        (f_valid),
    .cmd_ready        (f_ready),
    .cmd              (f_cmd)
  );

  srfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  srfr_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (b_valid),
    .cmd_ready      (b_ready),
    .cmd            (b_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_code_value (out_code_value),
    .out_read_word  (out_read_word)
  );

endmodule

/* tb/tb_servo_reply_frame_reassembler.sv */
// Self-checking testbench of the servo reply frame reassembler: directed table, random traffic.
module tb_servo_reply_frame_reassembler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_WORDS  = srfr_pkg::STORE_WORDS_DEF;
  localparam int PACK_LIMIT   = STORE_WORDS / srfr_pkg::WORDS_PER_PACK;
  localparam int DIR_ROWS     = 25;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 325;
  localparam int SETTLE       = 6;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [7:0] FC_UNUSED    = 8'hFF;

  typedef struct packed {
    logic [2:0]  op;
    logic        frame_valid;
    logic [7:0]  source_id;
    logic [7:0]  function_code;
    logic [3:0]  data_length;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [15:0] word_first;
    logic [15:0] word_second;
    logic [15:0] word_third;
    logic [4:0]  read_index;
  } frame_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [7:0]  code;
    logic [15:0] word;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic        in_frame_valid;
  logic [7:0]  in_source_id;
  logic [7:0]  in_function_code;
  logic [3:0]  in_data_length;
  logic [7:0]  in_byte_zero;
  logic [7:0]  in_byte_one;
  logic [15:0] in_word_first;
  logic [15:0] in_word_second;
  logic [15:0] in_word_third;
  logic [4:0]  in_read_index;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_event_res;
  logic [7:0]  out_code_value;
  logic [15:0] out_read_word;

  // Typed-in expectation carried alongside the request it belongs to
  logic   row_typed;
  reply_t row_reply;

  // Predictor state
  logic [15:0] pack_store [2][STORE_WORDS];
  logic [7:0]  next_pack [2];
  logic [3:0]  dev_nibble;
  reply_t      expected_replies [$];

  int mismatches      = 0;
  int results_checked = 0;
  int requests_taken  = 0;
  int transfers_done  = 0;
  int nibble_settings = 0;
  int sent_items      = 0;
  logic [3:0] cur_nibble = 4'h0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;

  servo_reply_frame_reassembler #(.STORE_WORDS(STORE_WORDS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_frame_valid  (in_frame_valid),
    .in_source_id    (in_source_id),
    .in_function_code(in_function_code),
    .in_data_length  (in_data_length),
    .in_byte_zero    (in_byte_zero),
    .in_byte_one     (in_byte_one),
    .in_word_first   (in_word_first),
    .in_word_second  (in_word_second),
    .in_word_third   (in_word_third),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_code_value  (out_code_value),
    .out_read_word   (out_read_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_model();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < STORE_WORDS; i++) pack_store[s][i] = 16'h0000;
      next_pack[s] = 8'd0;
    end
    dev_nibble = 4'h0;
  endfunction

  // Check one pack of a multi-frame transfer and store its words
  function automatic logic [3:0] take_pack(input frame_t f, input int sel,
                                           input logic [3:0] done_ev);
    int count, idx, len, n, pos;
    logic [15:0] w;
    count = int'(f.byte_zero);
    idx   = int'(f.byte_one);
    len   = int'(f.data_length);
    if (idx >= count || count > PACK_LIMIT ||
        len < int'(srfr_pkg::LEN_MIN) || len % 2 != 0 || len > int'(srfr_pkg::LEN_FULL) ||
        (len != int'(srfr_pkg::LEN_FULL) && idx != count - 1) ||
        idx != int'(next_pack[sel])) begin
      next_pack[sel] = 8'd0;
      return srfr_pkg::EV_PACK_BAD;
    end
    next_pack[sel] = next_pack[sel] + 8'd1;
    n = (len - 2) / 2;
    for (int i = 0; i < n; i++) begin
      pos = idx * srfr_pkg::WORDS_PER_PACK + i;
      case (i)
        0:       w = f.word_first;
        1:       w = f.word_second;
        default: w = f.word_third;
      endcase
      if (pos < STORE_WORDS) pack_store[sel][pos] = w;
    end
    if (idx + 1 == count) begin
      next_pack[sel] = 8'd0;
      return done_ev;
    end
    return srfr_pkg::EV_PACK_OK;
  endfunction

  function automatic reply_t predict_reply(input frame_t f);
    reply_t r;
    r.ev   = srfr_pkg::EV_IGNORED;
    r.code = 8'h00;
    r.word = 16'h0000;
    case (f.op)
      srfr_pkg::OP_FRAME: begin
        if (f.frame_valid && f.source_id[7:4] == dev_nibble) begin
          case (f.function_code)
            srfr_pkg::FC_ALARM: begin
              r.ev   = srfr_pkg::EV_ALARM;
              r.code = f.byte_zero;
            end
            srfr_pkg::FC_PARAM:     r.ev = take_pack(f, 0, srfr_pkg::EV_PARAM_DONE);
            srfr_pkg::FC_SET_ACK:   r.ev = srfr_pkg::EV_SET_ACK;
            srfr_pkg::FC_MONITOR:   r.ev = take_pack(f, 1, srfr_pkg::EV_MON_DONE);
            srfr_pkg::FC_ZERO_ACK:  r.ev = srfr_pkg::EV_ZERO_ACK;
            srfr_pkg::FC_ZERO_DONE: r.ev = srfr_pkg::EV_ZERO_DONE;
            srfr_pkg::FC_STATUS: begin
              r.ev   = srfr_pkg::EV_STATUS;
              r.code = f.byte_zero;
            end
            default: ;
          endcase
        end
      end
      srfr_pkg::OP_RD_PARAM, srfr_pkg::OP_RD_MON: begin
        r.ev = srfr_pkg::EV_READ;
        if (int'(f.read_index) < STORE_WORDS)
          r.word = pack_store[(f.op == srfr_pkg::OP_RD_MON) ? 1 : 0][f.read_index];
      end
      srfr_pkg::OP_RST_PARAM: next_pack[0] = 8'd0;
      srfr_pkg::OP_RST_MON:   next_pack[1] = 8'd0;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : reply_checker
    frame_t seen;
    reply_t got, want, pred;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_valid && out_ready) begin
        got.ev   = out_event_res;
        got.code = out_code_value;
        got.word = out_read_word;
        results_checked++;
        if (expected_replies.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: event %0d code %h word %h",
                     got.ev, got.code, got.word);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (got.ev !== want.ev || got.code !== want.code || got.word !== want.word) begin
            if (mismatches < 10)
              $display("mismatch on result %0d: event %0d/%0d code %h/%h word %h/%h %s",
                       results_checked, want.ev, got.ev, want.code, got.code,
                       want.word, got.word, "(expected/actual)");
            mismatches++;
          end
          if (want.ev == srfr_pkg::EV_PARAM_DONE || want.ev == srfr_pkg::EV_MON_DONE)
            transfers_done++;
        end
      end
      if (in_valid && in_ready) begin
        seen.op            = in_op;
        seen.frame_valid   = in_frame_valid;
        seen.source_id     = in_source_id;
        seen.function_code = in_function_code;
        seen.data_length   = in_data_length;
        seen.byte_zero     = in_byte_zero;
        seen.byte_one      = in_byte_one;
        seen.word_first    = in_word_first;
        seen.word_second   = in_word_second;
        seen.word_third    = in_word_third;
        seen.read_index    = in_read_index;
        pred = predict_reply(seen);
        expected_replies.push_back(row_typed ? row_reply : pred);
        requests_taken++;
      end
      if (cfg_we) dev_nibble = cfg_wdata;
    end
  end

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int w, taken, holds;
    taken = 0;
    holds = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      // hold off for a long stretch so the request queue fills and in_ready drops
      if ((holds == 0 && taken >= 500) || (holds == 1 && taken >= 1300)) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds++;
      end
      if ($urandom_range(0, 49) == 0) rx_burst = ~rx_burst;
      w = rx_burst ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic reply_t mk_reply(input logic [3:0] ev, input logic [7:0] code,
                                      input logic [15:0] word);
    reply_t r;
    r.ev   = ev;
    r.code = code;
    r.word = word;
    return r;
  endfunction

  function automatic frame_t mk_op(input logic [2:0] op, input logic [4:0] ridx);
    frame_t f;
    f            = '0;
    f.op         = op;
    f.read_index = ridx;
    return f;
  endfunction

  function automatic frame_t mk_frame(input logic fv, input logic [7:0] src,
                                      input logic [7:0] fc, input logic [3:0] len,
                                      input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [15:0] w1, input logic [15:0] w2,
                                      input logic [15:0] w3);
    frame_t f;
    f               = '0;
    f.op            = srfr_pkg::OP_FRAME;
    f.frame_valid   = fv;
    f.source_id     = src;
    f.function_code = fc;
    f.data_length   = len;
    f.byte_zero     = b0;
    f.byte_one      = b1;
    f.word_first    = w1;
    f.word_second   = w2;
    f.word_third    = w3;
    return f;
  endfunction

  // Directed table; the type nibble is still at its reset value of zero
  function automatic void dir_row(input int k, output frame_t f, output logic typed,
                                  output reply_t e);
    typed = 1'b1;
    e     = mk_reply(srfr_pkg::EV_IGNORED, 8'h00, 16'h0000);
    f     = mk_op(srfr_pkg::OP_RD_PARAM, 5'd0);
    case (k)
      0:  e = mk_reply(srfr_pkg::EV_READ, 8'h00, 16'h0000);
      1: begin
        f = mk_op(srfr_pkg::OP_RD_MON, 5'd29);
        e = mk_reply(srfr_pkg::EV_READ, 8'h00, 16'h0000);
      end
      2: begin
        f = mk_op(srfr_pkg::OP_RD_PARAM, 5'd31);
        e = mk_reply(srfr_pkg::EV_READ, 8'h00, 16'h0000);
      end
      3:  f = mk_frame(1'b0, 8'h00, srfr_pkg::FC_ALARM, srfr_pkg::LEN_FULL, 8'h55, 8'h00,
                       16'h0, 16'h0, 16'h0);
      4:  f = mk_frame(1'b1, 8'hF0, srfr_pkg::FC_ALARM, srfr_pkg::LEN_FULL, 8'h55, 8'h00,
                       16'h0, 16'h0, 16'h0);
      5: begin
        f = mk_frame(1'b1, 8'h0F, srfr_pkg::FC_ALARM, srfr_pkg::LEN_FULL, 8'hFF, 8'hFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF);
        e = mk_reply(srfr_pkg::EV_ALARM, 8'hFF, 16'h0000);
      end
      6: begin
        f = mk_frame(1'b1, 8'h00, srfr_pkg::FC_STATUS, 4'd0, 8'h00, 8'h00,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_STATUS, 8'h00, 16'h0000);
      end
      7: begin
        f = mk_frame(1'b1, 8'h03, srfr_pkg::FC_SET_ACK, 4'd15, 8'hAA, 8'h00,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_SET_ACK, 8'h00, 16'h0000);
      end
      8: begin
        f = mk_frame(1'b1, 8'h05, srfr_pkg::FC_ZERO_ACK, srfr_pkg::LEN_MIN, 8'h01, 8'h00,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_ZERO_ACK, 8'h00, 16'h0000);
      end
      9: begin
        f = mk_frame(1'b1, 8'h0A, srfr_pkg::FC_ZERO_DONE, srfr_pkg::LEN_MID, 8'h02, 8'h00,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_ZERO_DONE, 8'h00, 16'h0000);
      end
      10: f = mk_frame(1'b1, 8'h00, FC_UNUSED, srfr_pkg::LEN_FULL, 8'h14, 8'h00,
                       16'h0, 16'h0, 16'h0);
      11: begin
        f = mk_frame(1'b1, 8'h01, srfr_pkg::FC_PARAM, srfr_pkg::LEN_FULL, 8'd10, 8'd0,
                     16'hFFFF, 16'h0000, 16'hFFFF);
        e = mk_reply(srfr_pkg::EV_PACK_OK, 8'h00, 16'h0000);
      end
      12: begin
        f = mk_frame(1'b1, 8'h01, srfr_pkg::FC_PARAM, srfr_pkg::LEN_FULL, 8'd10, 8'd1,
                     16'h1234, 16'hABCD, 16'h8001);
        e = mk_reply(srfr_pkg::EV_PACK_OK, 8'h00, 16'h0000);
      end
      13: begin
        // short last pack: only one word goes in
        f = mk_frame(1'b1, 8'h01, srfr_pkg::FC_PARAM, srfr_pkg::LEN_MIN, 8'd3, 8'd2,
                     16'h5A5A, 16'h1111, 16'h2222);
        e = mk_reply(srfr_pkg::EV_PARAM_DONE, 8'h00, 16'h0000);
      end
      14: begin
        f     = mk_op(srfr_pkg::OP_RD_PARAM, 5'd0);
        typed = 1'b0;
      end
      15: begin
        f     = mk_op(srfr_pkg::OP_RD_PARAM, 5'd7);
        typed = 1'b0;
      end
      16: begin
        f = mk_frame(1'b1, 8'h02, srfr_pkg::FC_MONITOR, srfr_pkg::LEN_FULL, 8'd11, 8'd0,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_PACK_BAD, 8'h00, 16'h0000);
      end
      17: begin
        f = mk_frame(1'b1, 8'h02, srfr_pkg::FC_MONITOR, 4'd5, 8'd1, 8'd0,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_PACK_BAD, 8'h00, 16'h0000);
      end
      18: begin
        f = mk_frame(1'b1, 8'h02, srfr_pkg::FC_MONITOR, srfr_pkg::LEN_MID, 8'd2, 8'd0,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_PACK_BAD, 8'h00, 16'h0000);
      end
      19: begin
        f = mk_frame(1'b1, 8'h02, srfr_pkg::FC_MONITOR, srfr_pkg::LEN_FULL, 8'd2, 8'd1,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_PACK_BAD, 8'h00, 16'h0000);
      end
      20: begin
        f = mk_frame(1'b1, 8'h02, srfr_pkg::FC_MONITOR, srfr_pkg::LEN_FULL, 8'd1, 8'd1,
                     16'h0, 16'h0, 16'h0);
        e = mk_reply(srfr_pkg::EV_PACK_BAD, 8'h00, 16'h0000);
      end
      21: begin
        f = mk_frame(1'b1, 8'h02, srfr_pkg::FC_MONITOR, srfr_pkg::LEN_MID, 8'd1, 8'd0,
                     16'hFFFF, 16'hFFFF, 16'hFFFF);
        e = mk_reply(srfr_pkg::EV_MON_DONE, 8'h00, 16'h0000);
      end
      22: begin
        f     = mk_op(srfr_pkg::OP_RD_MON, 5'd1);
        typed = 1'b0;
      end
      23: f = mk_op(srfr_pkg::OP_RST_PARAM, 5'd0);
      default: f = mk_op(OP_UNUSED_HI, 5'd31);
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    f.op            = 3'($urandom);
    f.frame_valid   = 1'($urandom);
    f.source_id     = 8'($urandom);
    f.function_code = 8'($urandom);
    f.data_length   = 4'($urandom);
    f.byte_zero     = 8'($urandom);
    f.byte_one      = 8'($urandom);
    f.word_first    = 16'($urandom);
    f.word_second   = 16'($urandom);
    f.word_third    = 16'($urandom);
    f.read_index    = 5'($urandom);
    return f;
  endfunction

  function automatic frame_t pack_frame(input logic sel, input int count, input int idx,
                                        input int len);
    frame_t f;
    f                 = rand_frame();
    f.op              = srfr_pkg::OP_FRAME;
    f.frame_valid     = 1'b1;
    f.source_id[7:4]  = cur_nibble;
    f.function_code   = sel ? srfr_pkg::FC_MONITOR : srfr_pkg::FC_PARAM;
    f.data_length     = 4'(len);
    f.byte_zero       = 8'(count);
    f.byte_one        = 8'(idx);
    return f;
  endfunction

  function automatic frame_t read_frame(input logic sel, input int idx);
    frame_t f;
    f            = rand_frame();
    f.op         = sel ? srfr_pkg::OP_RD_MON : srfr_pkg::OP_RD_PARAM;
    f.read_index = 5'(idx);
    return f;
  endfunction

  function automatic frame_t restart_frame(input logic sel);
    frame_t f;
    f    = rand_frame();
    f.op = sel ? srfr_pkg::OP_RST_MON : srfr_pkg::OP_RST_PARAM;
    return f;
  endfunction

  function automatic int last_len();
    case ($urandom_range(0, 2))
      0:       return int'(srfr_pkg::LEN_MIN);
      1:       return int'(srfr_pkg::LEN_MID);
      default: return int'(srfr_pkg::LEN_FULL);
    endcase
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input frame_t f, input logic typed, input reply_t e);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= f.op;
    in_frame_valid   <= f.frame_valid;
    in_source_id     <= f.source_id;
    in_function_code <= f.function_code;
    in_data_length   <= f.data_length;
    in_byte_zero     <= f.byte_zero;
    in_byte_one      <= f.byte_one;
    in_word_first    <= f.word_first;
    in_word_second   <= f.word_second;
    in_word_third    <= f.word_third;
    in_read_index    <= f.read_index;
    row_typed        <= typed;
    row_reply        <= e;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic drain_replies();
    in_valid  <= 1'b0;
    row_typed <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_type_nibble(input logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_nibble = v;
    nibble_settings++;
  endtask

  // A multi-frame transfer, now and then broken or interleaved with other requests
  task automatic run_transfer();
    frame_t f;
    logic sel;
    int count, len, r, reads;
    sel   = 1'($urandom);
    count = $urandom_range(1, PACK_LIMIT);
    for (int k = 0; k < count; k++) begin
      len = (k == count - 1) ? last_len() : int'(srfr_pkg::LEN_FULL);
      f   = pack_frame(sel, count, k, len);
      r   = $urandom_range(0, 99);
      if (r < 3)       f.byte_one = 8'($urandom_range(0, 15));
      else if (r < 6)  f.data_length = 4'($urandom);
      else if (r < 8)  f.frame_valid = 1'b0;
      else if (r < 10) f.source_id[7:4] = 4'($urandom);
      else if (r < 12) f.byte_zero = 8'($urandom_range(0, 15));
      else if (r < 14) send_req(restart_frame(sel), 1'b0, '0);
      else if (r < 17) send_req(read_frame(1'($urandom), $urandom_range(0, STORE_WORDS - 1)),
                                1'b0, '0);
      send_req(f, 1'b0, '0);
    end
    if ($urandom_range(0, 1) == 1) begin
      reads = $urandom_range(1, 4);
      for (int k = 0; k < reads; k++)
        send_req(read_frame(sel, $urandom_range(0, count * srfr_pkg::WORDS_PER_PACK - 1)),
                 1'b0, '0);
    end
  endtask

  task automatic random_step();
    frame_t f;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      run_transfer();
    end else if (r < 70) begin
      if ($urandom_range(0, 9) == 0)
        f = read_frame(1'($urandom), $urandom_range(STORE_WORDS, 31));
      else
        f = read_frame(1'($urandom), $urandom_range(0, STORE_WORDS - 1));
      send_req(f, 1'b0, '0);
    end else if (r < 85) begin
      f             = rand_frame();
      f.op          = srfr_pkg::OP_FRAME;
      f.frame_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) != 0) f.source_id[7:4] = cur_nibble;
      case ($urandom_range(0, 7))
        0:       f.function_code = srfr_pkg::FC_ALARM;
        1:       f.function_code = srfr_pkg::FC_STATUS;
        2:       f.function_code = srfr_pkg::FC_SET_ACK;
        3:       f.function_code = srfr_pkg::FC_ZERO_ACK;
        4:       f.function_code = srfr_pkg::FC_ZERO_DONE;
        5:       f.function_code = srfr_pkg::FC_ALARM;
        6:       f.function_code = srfr_pkg::FC_STATUS;
        default: ;
      endcase
      send_req(f, 1'b0, '0);
    end else if (r < 95) begin
      send_req(rand_frame(), 1'b0, '0);
    end else begin
      f    = rand_frame();
      f.op = 3'($urandom_range(int'(srfr_pkg::OP_RST_PARAM), int'(OP_UNUSED_HI)));
      send_req(f, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    frame_t f;
    logic typed;
    reply_t e;
    int phase_end;
    logic [3:0] nib;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 4'h0;
    in_valid         = 1'b0;
    in_op            = srfr_pkg::OP_FRAME;
    in_frame_valid   = 1'b0;
    in_source_id     = 8'h00;
    in_function_code = 8'h00;
    in_data_length   = 4'd0;
    in_byte_zero     = 8'h00;
    in_byte_one      = 8'h00;
    in_word_first    = 16'h0000;
    in_word_second   = 16'h0000;
    in_word_third    = 16'h0000;
    in_read_index    = 5'd0;
    out_ready        = 1'b0;
    row_typed        = 1'b0;
    row_reply        = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      dir_row(k, f, typed, e);
      send_req(f, typed, e);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      case (p)
        0:       nib = 4'hF;
        1:       nib = 4'h0;
        5:       nib = 4'hF;
        default: nib = 4'($urandom);
      endcase
      write_type_nibble(nib);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) random_step();
    end
    drain_replies();

    $display("%0d requests accepted, %0d results checked, %0d transfers completed",
             requests_taken, results_checked, transfers_done);
    $display("%0d device type settings, %0d mismatches", nibble_settings, mismatches);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
